// ----- rtl/rgb_to_hsl_convert_unit_defines.svh -----
// Assertion macros shared by the RGB to HSL conversion RTL.
// Depends on nothing; using files must have i_clk and i_rst_n in scope.
`ifndef RGB_TO_HSL_CONVERT_UNIT_DEFINES_SVH
`define RGB_TO_HSL_CONVERT_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define RHC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define RHC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RHC_ASSERT_IMP(lbl, ante, cons, msg)
`define RHC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/rhc_pkg.sv -----
// Types, constants and helper functions for the RGB to HSL pipeline.
// No dependencies.
package rhc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int FW        = FRAC_BITS + 1;          // unsigned Q1.16 values in [0, 1]
    localparam logic [FW-1:0]  FRAC_ONE  = 17'd65536;
    localparam logic [FW-1:0]  FRAC_HALF = 17'd32768;
    localparam logic [FW:0]    FRAC_TWO  = 18'd131072;
    localparam logic [18:0]    FRAC_SIX  = 19'd393216;
    // ceil(2^22 / 6): multiply then shift right 22 gives floor(h / 6)
    localparam int             DIV6_SHIFT = 22;
    localparam logic [19:0]    DIV6_MUL   = 20'd699051;
    localparam int             DIV_STEPS  = FRAC_BITS + 1;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] hue_out;
        logic [7:0] saturation_out;
        logic [7:0] lightness_out;
    } t_pix_out;

    // side data that rides along with the divider
    typedef struct packed {
        logic          grey;
        logic          neg;     // hue quotient is negated
        logic [2:0]    off;     // hue sextant offset in whole units
        logic [FW-1:0] light;
    } t_div_side;

    typedef struct packed {
        logic          vld;
        logic [FW-1:0] x_s;
        logic [FW-1:0] d_s;
        logic [FW-1:0] x_h;
        logic [FW-1:0] d_h;
        t_div_side     side;
    } t_div_in;

    typedef struct packed {
        logic          vld;
        logic [FW-1:0] q_s;
        logic [FW-1:0] q_h;
        t_div_side     side;
    } t_div_out;

    // (c << 16) / 255 truncated equals 257*c, plus one at full scale
    function automatic logic [FW-1:0] to_frac(input logic [7:0] c);
        logic [FW-1:0] v;
        v = {1'b0, c, c};
        if (c == 8'hFF) begin
            v = v + 17'd1;
        end
        return v;
    endfunction

    // (v * 255 + 32768) >> 16; v * 256 needs the full 25 bits at v = 1.0
    function automatic logic [7:0] to_byte(input logic [FW-1:0] v);
        logic [24:0] t;
        t = {v, 8'd0} - {8'd0, v} + 25'd32768;
        return t[23:16];
    endfunction

endpackage

// ----- rtl/rhc_front.sv -----
// Front stages: channel scaling, max/min, lightness and divider setup.
// Depends on rhc_pkg.
module rhc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  rhc_pkg::t_pix_in i_pix,
    output rhc_pkg::t_div_in o_div
);

    logic                   r_a_vld;
    logic [rhc_pkg::FW-1:0] r_r, r_g, r_b;
    rhc_pkg::t_div_in       r_div;
    rhc_pkg::t_div_in       n_div;

    // stage A: scale to Q1.16
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
        end
        r_r <= rhc_pkg::to_frac(i_pix.red_in);
        r_g <= rhc_pkg::to_frac(i_pix.green_in);
        r_b <= rhc_pkg::to_frac(i_pix.blue_in);
    end

    // stage B: extremes, lightness, divisors and hue branch
    always_comb begin
        logic [rhc_pkg::FW-1:0] mx, mn, dlt;
        logic [rhc_pkg::FW:0]   sum;
        mx = r_r;
        mn = r_r;
        if (r_g > mx) mx = r_g;
        if (r_b > mx) mx = r_b;
        if (r_g < mn) mn = r_g;
        if (r_b < mn) mn = r_b;
        sum = {1'b0, mx} + {1'b0, mn};
        dlt = mx - mn;

        n_div            = '0;
        n_div.vld        = r_a_vld;
        n_div.side.grey  = (dlt == '0);
        n_div.side.light = sum[rhc_pkg::FW:1];
        n_div.x_s        = dlt;
        n_div.d_h        = dlt;
        if (sum[rhc_pkg::FW:1] > rhc_pkg::FRAC_HALF) begin
            n_div.d_s = rhc_pkg::FW'(rhc_pkg::FRAC_TWO - sum);
        end else begin
            n_div.d_s = sum[rhc_pkg::FW-1:0];
        end

        if (r_r == mx) begin
            n_div.side.neg = (r_g < r_b);
            n_div.x_h      = (r_g < r_b) ? (r_b - r_g) : (r_g - r_b);
            n_div.side.off = (r_g < r_b) ? 3'd6 : 3'd0;
        end else if (r_g == mx) begin
            n_div.side.neg = (r_b < r_r);
            n_div.x_h      = (r_b < r_r) ? (r_r - r_b) : (r_b - r_r);
            n_div.side.off = 3'd2;
        end else begin
            n_div.side.neg = (r_r < r_g);
            n_div.x_h      = (r_r < r_g) ? (r_g - r_r) : (r_r - r_g);
            n_div.side.off = 3'd4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div.vld <= 1'b0;
        end else begin
            r_div.vld <= n_div.vld;
        end
        r_div.x_s  <= n_div.x_s;
        r_div.d_s  <= n_div.d_s;
        r_div.x_h  <= n_div.x_h;
        r_div.d_h  <= n_div.d_h;
        r_div.side <= n_div.side;
    end

    assign o_div = r_div;

endmodule

// ----- rtl/rhc_div.sv -----
// Two-lane pipelined restoring divider: (x << 16) / d for x <= d, one bit per stage.
// Depends on rhc_pkg.
module rhc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rhc_pkg::t_div_in  i_div,
    output rhc_pkg::t_div_out o_div
);

    localparam int N  = rhc_pkg::DIV_STEPS;
    localparam int FW = rhc_pkg::FW;

    logic               r_vld  [N];
    logic [FW-1:0]      r_rem_s[N];
    logic [FW-1:0]      r_rem_h[N];
    logic [FW-1:0]      r_q_s  [N];
    logic [FW-1:0]      r_q_h  [N];
    logic [FW-1:0]      r_d_s  [N];
    logic [FW-1:0]      r_d_h  [N];
    rhc_pkg::t_div_side r_side [N];

    logic [FW-1:0]      n_rem_s[N];
    logic [FW-1:0]      n_rem_h[N];
    logic [FW-1:0]      n_q_s  [N];
    logic [FW-1:0]      n_q_h  [N];

    // one quotient bit per stage; first stage yields the integer bit
    always_comb begin
        logic [FW:0] ts, th;
        for (int k = 0; k < N; k++) begin
            if (k == 0) begin
                ts = {1'b0, i_div.x_s};
                th = {1'b0, i_div.x_h};
                n_q_s[k] = '0;
                n_q_h[k] = '0;
            end else begin
                ts = {r_rem_s[k-1], 1'b0};
                th = {r_rem_h[k-1], 1'b0};
                n_q_s[k] = {r_q_s[k-1][FW-2:0], 1'b0};
                n_q_h[k] = {r_q_h[k-1][FW-2:0], 1'b0};
            end
            if (ts >= {1'b0, (k == 0) ? i_div.d_s : r_d_s[k-1]}) begin
                ts          = ts - {1'b0, (k == 0) ? i_div.d_s : r_d_s[k-1]};
                n_q_s[k][0] = 1'b1;
            end
            if (th >= {1'b0, (k == 0) ? i_div.d_h : r_d_h[k-1]}) begin
                th          = th - {1'b0, (k == 0) ? i_div.d_h : r_d_h[k-1]};
                n_q_h[k][0] = 1'b1;
            end
            n_rem_s[k] = ts[FW-1:0];
            n_rem_h[k] = th[FW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N; k++) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= (k == 0) ? i_div.vld : r_vld[k-1];
            end
            r_rem_s[k] <= n_rem_s[k];
            r_rem_h[k] <= n_rem_h[k];
            r_q_s[k]   <= n_q_s[k];
            r_q_h[k]   <= n_q_h[k];
            r_d_s[k]   <= (k == 0) ? i_div.d_s  : r_d_s[k-1];
            r_d_h[k]   <= (k == 0) ? i_div.d_h  : r_d_h[k-1];
            r_side[k]  <= (k == 0) ? i_div.side : r_side[k-1];
        end
    end

    assign o_div.vld  = r_vld[N-1];
    assign o_div.q_s  = r_q_s[N-1];
    assign o_div.q_h  = r_q_h[N-1];
    assign o_div.side = r_side[N-1];

endmodule

// ----- rtl/rhc_back.sv -----
// Back stages: hue assembly, divide by six, rounding to bytes.
// Depends on rhc_pkg and rgb_to_hsl_convert_unit_defines.svh.
`include "rgb_to_hsl_convert_unit_defines.svh"
module rhc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rhc_pkg::t_div_out i_div,
    output logic              o_vld,
    output rhc_pkg::t_pix_out o_res
);

    localparam int FW = rhc_pkg::FW;

    logic              r_c_vld, r_d_vld, r_e_vld;
    logic [18:0]       r_c_h;
    logic [FW-1:0]     r_c_s, r_c_l;
    logic [38:0]       r_d_prod;
    logic [7:0]        r_d_s, r_d_l;
    rhc_pkg::t_pix_out r_e_res;
    logic [18:0]       n_h;

    // stage C: sextant offset plus signed quotient
    always_comb begin
        n_h = {i_div.side.off, 16'd0};
        if (i_div.side.neg) begin
            n_h = n_h - {2'd0, i_div.q_h};
        end else begin
            n_h = n_h + {2'd0, i_div.q_h};
        end
        if (i_div.side.grey) begin
            n_h = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
        end else begin
            r_c_vld <= i_div.vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
        end
        r_c_h <= n_h;
        r_c_s <= i_div.side.grey ? '0 : i_div.q_s;
        r_c_l <= i_div.side.light;
        // stage D: h / 6 by reciprocal
        r_d_prod <= {20'd0, r_c_h} * {19'd0, rhc_pkg::DIV6_MUL};
        r_d_s    <= rhc_pkg::to_byte(r_c_s);
        r_d_l    <= rhc_pkg::to_byte(r_c_l);
        // stage E: round hue
        r_e_res.hue_out        <= rhc_pkg::to_byte(
            r_d_prod[rhc_pkg::DIV6_SHIFT + FW - 1:rhc_pkg::DIV6_SHIFT]);
        r_e_res.saturation_out <= r_d_s;
        r_e_res.lightness_out  <= r_d_l;
    end

    assign o_vld = r_e_vld;
    assign o_res = r_e_res;

    `RHC_ASSERT_IMP(a_hue_range, r_c_vld, r_c_h < rhc_pkg::FRAC_SIX, "hue above full circle")
    `RHC_ASSERT_IMP(a_sat_range, r_c_vld, r_c_s <= rhc_pkg::FRAC_ONE, "saturation above one")
    `RHC_ASSERT_NXT(a_vld_flow, r_c_vld, r_d_vld && !$stable(r_d_prod) || r_d_vld,
        "valid lost between stages")

endmodule

// ----- rtl/rgb_to_hsl_convert_unit.sv -----
// RGB to HSL conversion, top level: front stages A and B, divider, back stages C to E.
// A new pixel is taken every cycle (o_busy stays low), set by the
// 17-stage bit-per-stage divider pipeline. Results are strobed for one cycle.
// Synchronous active-low reset clears all valid bits; data registers are not reset.
// Depends on rhc_pkg, rhc_front, rhc_div, rhc_back.
module rgb_to_hsl_convert_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  rhc_pkg::t_pix_in  i_pix,
    output logic              o_valid,
    output rhc_pkg::t_pix_out o_res
);

    rhc_pkg::t_div_in  w_div_in;
    rhc_pkg::t_div_out w_div_out;

    // pipeline never stalls
    assign o_busy = 1'b0;

    rhc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_start),
        .i_pix   (i_pix),
        .o_div   (w_div_in)
    );

    rhc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_div   (w_div_in),
        .o_div   (w_div_out)
    );

    rhc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_div   (w_div_out),
        .o_vld   (o_valid),
        .o_res   (o_res)
    );

endmodule

// ----- sim/rgb_to_hsl_convert_unit_checker.sv -----
// Scoreboard for the RGB to HSL conversion unit: predicts each pixel's HSL
// result at transfer time and compares strobed results in order.
// Depends on rhc_pkg.
`timescale 1ns / 1ps

module rgb_to_hsl_convert_unit_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  rhc_pkg::t_pix_in  i_pix,
    input  logic              i_valid,
    input  rhc_pkg::t_pix_out i_res,
    output int                o_fail_count,
    output int                o_pending
);

    localparam longint ONE = 65536;

    rhc_pkg::t_pix_out hsl_expected_q[$];

    // channel byte to 16.16 fraction, truncating
    function automatic longint chan_frac(input logic [7:0] c);
        return (longint'(c) * ONE) / 255;
    endfunction

    // 16.16 fraction back to a rounded byte
    function automatic logic [7:0] frac_byte(input longint v);
        longint t;
        if (v < 0) v = 0;
        t = (v * 255 + ONE / 2) / ONE;
        return t[7:0];
    endfunction

    // 16.16 quotient, truncated toward zero
    function automatic longint fdiv(input longint n, input longint d);
        return (d == 0) ? 0 : (n * ONE) / d;
    endfunction

    function automatic rhc_pkg::t_pix_out predict_hsl(input rhc_pkg::t_pix_in p);
        longint r, g, b, mx, mn, h, s, l, dl;
        rhc_pkg::t_pix_out o;
        r = chan_frac(p.red_in);
        g = chan_frac(p.green_in);
        b = chan_frac(p.blue_in);
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        l = (mx + mn) / 2;
        dl = mx - mn;
        h = 0; s = 0;
        if (dl != 0) begin
            if (l > ONE / 2) s = fdiv(dl, 2 * ONE - mx - mn);
            else s = fdiv(dl, mx + mn);
            if (r == mx) begin
                h = fdiv(g - b, dl);
                if (g < b) h += 6 * ONE;
            end else if (g == mx) begin
                h = fdiv(b - r, dl) + 2 * ONE;
            end else begin
                h = fdiv(r - g, dl) + 4 * ONE;
            end
            h = fdiv(h, 6 * ONE);
        end
        o.hue_out = frac_byte(h);
        o.saturation_out = frac_byte(s);
        o.lightness_out = frac_byte(l);
        return o;
    endfunction

    assign o_pending = hsl_expected_q.size();

    // queue a prediction per input transfer, compare each strobed result
    always @(posedge i_clk) begin
        rhc_pkg::t_pix_out want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            hsl_expected_q.delete();
        end else begin
            if (i_start && !i_busy) hsl_expected_q.push_back(predict_hsl(i_pix));
            if (i_valid) begin
                if (hsl_expected_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_res);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = hsl_expected_q.pop_front();
                    if (want.hue_out !== i_res.hue_out
                        || want.saturation_out !== i_res.saturation_out
                        || want.lightness_out !== i_res.lightness_out) begin
                        $display("%0t: mismatch expected h=%0d s=%0d l=%0d actual h=%0d s=%0d l=%0d",
                                 $time, want.hue_out, want.saturation_out, want.lightness_out,
                                 i_res.hue_out, i_res.saturation_out, i_res.lightness_out);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- sim/tb_rgb_to_hsl_convert_unit.sv -----
// Testbench top for rgb_to_hsl_convert_unit: drives directed and random pixels
// with random idle bursts; checking is done in rgb_to_hsl_convert_unit_checker.
// Depends on rhc_pkg, the unit RTL and the checker.
`timescale 1ns / 1ps

module tb_rgb_to_hsl_convert_unit;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_start;
    logic              o_busy;
    rhc_pkg::t_pix_in  i_pix;
    logic              o_valid;
    rhc_pkg::t_pix_out o_res;
    int                fail_count;
    int                pending;

    rgb_to_hsl_convert_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_pix(i_pix), .o_valid(o_valid), .o_res(o_res)
    );

    rgb_to_hsl_convert_unit_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_busy(o_busy),
        .i_pix(i_pix), .i_valid(o_valid), .i_res(o_res),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #400000;
        $display("TB_ERROR");
        $finish;
    end

    // one pixel transfer; holds start until accepted
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
        i_start <= 1'b1;
        i_pix <= '{red_in: r, green_in: g, blue_in: b};
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic idle_cycles(input int n);
        i_start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // mostly random, sometimes grey or tied channels
    task automatic send_random;
        logic [7:0] r, g, b;
        r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
        case ($urandom_range(0, 7))
            0: begin g = r; b = r; end
            1: g = r;
            2: b = g;
            3: b = r;
            default: ;
        endcase
        send_pixel(r, g, b);
    endtask

    initial begin
        int wait_cnt;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_pix = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, greys, each max branch, ties, hue wrap
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd1, 8'd0);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd200, 8'd100, 8'd50);
        send_pixel(8'd50, 8'd200, 8'd100);
        send_pixel(8'd100, 8'd50, 8'd200);
        send_pixel(8'd127, 8'd128, 8'd0);
        send_pixel(8'd170, 8'd85, 8'd85);
        send_pixel(8'd1, 8'd2, 8'd3);
        send_pixel(8'd254, 8'd253, 8'd255);

        // random with idle bursts
        for (int n = 0; n < 750; n++) begin
            if ($urandom_range(0, 9) == 0) idle_cycles($urandom_range(1, 19));
            send_random();
        end
        // back-to-back tail
        for (int n = 0; n < 150; n++) send_random();
        i_start <= 1'b0;

        wait_cnt = 0;
        while (pending != 0 && wait_cnt < 1000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (30) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
